// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority ready queue
// Request and result layouts, operation codes and the queue capacity.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ID_W     = 6;
	localparam int PRIO_W   = 8;
	localparam int OCC_W    = 7;

	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [ID_W-1:0]   entry_id;
		logic [PRIO_W-1:0] priority_req;
	} spq_req_t;

	typedef struct packed {
		logic [ID_W-1:0]   out_entry_id;
		logic [PRIO_W-1:0] out_priority;
		logic              out_valid;
		logic              empty_error;
		logic              full_error;
		logic [OCC_W-1:0]  occupancy;
	} spq_result_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} spq_entry_t;

	typedef struct packed {
		logic enq;
		logic deq;
	} spq_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/stable_priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_ready_queue: bounded priority ready queue
// Sorted chain of cells, head in cell 0; FIFO order among equal priorities.
// ----------------------------------------------------------------------------
//  channel   signals                  direction  handshake
//  request   start, busy, request     in         taken when start && !busy
//  result    done, result             out        one-cycle strobe on done
//
// One request per cycle; its result appears on the cycle after acceptance.
// Every cell decides from its own and its left neighbor's compare, so an
// insert or removal updates every cell of the chain on the same clock edge.
// busy never rises. Reset empties the queue at once (count cleared).
// The receiver cannot stall: done is high for one cycle per result, and result holds until the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_ready_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  spq_pkg::spq_req_t    request,
	output logic                 done,
	output spq_pkg::spq_result_t result
);

	localparam int N = spq_pkg::CAPACITY;
	localparam int W = spq_pkg::CNT_W;

	logic [W-1:0]           count_q;
	logic                   done_q;
	spq_pkg::spq_result_t   result_q;
	spq_pkg::spq_cell_ctrl_t ctrl;
	spq_pkg::spq_entry_t    new_entry;
	spq_pkg::spq_entry_t    cell_entry [N];
	logic [N-1:0]           cell_disp;
	logic [N-1:0]           cell_occ;
	logic                   accept;
	logic                   is_deq;
	logic                   full;
	logic                   empty;
	logic [W-1:0]           next_count;
	spq_pkg::spq_result_t   res_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign is_deq = (request.operation == spq_pkg::OP_DEQUEUE);
	assign full   = (count_q == W'(N));
	assign empty  = (count_q == '0);

	assign ctrl.enq = accept && !is_deq && !full;
	assign ctrl.deq = accept && is_deq && !empty;

	assign new_entry.id   = request.entry_id;
	assign new_entry.prio = request.priority_req;

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_cell
			spq_pkg::spq_entry_t left_e;
			spq_pkg::spq_entry_t right_e;
			logic                left_d;

			assign cell_occ[i] = (count_q > W'(i));

			if (i == 0) begin : g_head
				assign left_e = new_entry;
				assign left_d = 1'b0;
			end else begin : g_mid
				assign left_e = cell_entry[i-1];
				assign left_d = cell_disp[i-1];
			end

			if (i == N - 1) begin : g_tail
				assign right_e = '0;
			end else begin : g_inner
				assign right_e = cell_entry[i+1];
			end

			spq_cell u_cell (
				.clk            (clk),
				.ctrl           (ctrl),
				.occupied       (cell_occ[i]),
				.new_entry      (new_entry),
				.left_displaced (left_d),
				.left_entry     (left_e),
				.right_entry    (right_e),
				.displaced      (cell_disp[i]),
				.entry          (cell_entry[i])
			);
		end
	endgenerate

	always_comb begin
		next_count = count_q;
		if (ctrl.enq) begin
			next_count = count_q + W'(1);
		end else if (ctrl.deq) begin
			next_count = count_q - W'(1);
		end
	end

	always_comb begin
		res_d              = '0;
		res_d.occupancy    = spq_pkg::OCC_W'(next_count);
		res_d.full_error   = !is_deq && full;
		res_d.empty_error  = is_deq && empty;
		if (ctrl.deq) begin
			res_d.out_entry_id = cell_entry[0].id;
			res_d.out_priority = cell_entry[0].prio;
			res_d.out_valid    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= next_count;
			end
		end
	end

	// hold the result payload only when a request is taken
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted cell chain
// Holds one entry; on insert it keeps, takes the new entry or takes the left
// neighbor's entry; on removal it takes the right neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
	input  wire                    clk,
	input  spq_pkg::spq_cell_ctrl_t ctrl,
	input  wire                    occupied,
	input  spq_pkg::spq_entry_t    new_entry,
	input  wire                    left_displaced,
	input  spq_pkg::spq_entry_t    left_entry,
	input  spq_pkg::spq_entry_t    right_entry,
	output logic                   displaced,
	output spq_pkg::spq_entry_t    entry
);

	spq_pkg::spq_entry_t entry_q;

	// equal priority stays in place, so a new entry lands behind its peers
	assign displaced = !occupied || (entry_q.prio < new_entry.prio);
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (displaced) begin
				entry_q <= left_displaced ? left_entry : new_entry;
			end
		end else if (ctrl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire
